FILE: sv/lrupr_pkg.sv
// Shared constants and update opcodes for the LRU page replacement block.
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int CFG_W        = 4;
  localparam int PAGE_FIELD_W = 16;
  localparam int SLOT_W       = 3;
  localparam int FAULT_W      = 32;
  localparam int OUT_DATA_W   = 40;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 4'd8;

  // Broadcast from the control logic to every frame cell.
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_TOUCH,
    UPD_FILL,
    UPD_CLEAR
  } upd_op_t;

endpackage

FILE: sv/lrupr_cell.sv
// One frame cell: holds a resident page and its recency, scans and applies updates.
`timescale 1ns / 1ps

module lrupr_cell #(
  parameter int  IDX = 0,
  parameter int  IW  = 3,
  parameter int  RW  = 3,
  parameter int  CW  = 4,
  parameter int  PW  = 16,
  parameter type scan_t = logic,
  parameter type upd_t  = logic
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [CW-1:0] act_cnt,
  input  scan_t         acc_in,
  output scan_t         acc_out,
  input  upd_t          upd
);
  import lrupr_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_POS = CW'(IDX);

  logic [PW-1:0] page;
  logic          valid;
  logic [RW-1:0] rank;
  logic          active;
  scan_t         acc_next;

  assign active = MY_POS < act_cnt;

  // Fold this frame into the record passing along the row.
  always_comb begin
    acc_next = acc_in;
    if (active) begin
      if (valid && page == acc_in.page && !acc_in.hit) begin
        acc_next.hit      = 1'b1;
        acc_next.hit_idx  = MY_IDX;
        acc_next.hit_rank = rank;
      end
      if (!valid && !acc_in.empty) begin
        acc_next.empty     = 1'b1;
        acc_next.empty_idx = MY_IDX;
      end
      // strict compare keeps the lower index on a tie
      if (IDX == 0 || (valid && rank < acc_in.min_rank)) begin
        acc_next.min_idx  = MY_IDX;
        acc_next.min_rank = rank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_out.vld <= 1'b0;
    end else begin
      acc_out <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      unique case (upd.op)
        UPD_CLEAR: begin
          valid <= 1'b0;
          rank  <= '0;
        end
        UPD_TOUCH: begin
          if (upd.slot == MY_IDX) begin
            rank <= upd.new_rank;
          end else if (valid && rank > upd.old_rank) begin
            rank <= rank - 1'b1;
          end
        end
        UPD_FILL: begin
          if (upd.slot == MY_IDX) begin
            valid <= 1'b1;
            rank  <= upd.new_rank;
          end
        end
        UPD_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((upd.op == UPD_TOUCH || upd.op == UPD_FILL) && upd.slot == MY_IDX && upd.wr_page) begin
      page <= upd.page;
    end
  end

endmodule

FILE: sv/lru_page_replacement.sv
// Each reference passes as a record through the registered row of frame cells, then the
// finished-scan register, and then the output register that drives m_tvalid. The next reference is
// accepted only once the update for the current one has been applied after its record walks the row.
// A new reference is taken while the previous result still waits on the output.
// Reset (rst, synchronous) empties all frames, zeroes the fault count, sets frame_count to 8.
`timescale 1ns / 1ps

module lru_page_replacement #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]        cfg_wdata,   // frame_count
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [lrupr_pkg::PAGE_FIELD_W-1:0] s_tdata,     // page_number[15:0]
  input  logic                               s_tlast,     // last_reference
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lrupr_pkg::OUT_DATA_W-1:0]   m_tdata,     // frame_slot[2:0], fault_count[34:3]
  output logic                               m_tuser,     // hit
  output logic                               m_tlast      // sequence_end
);
  import lrupr_pkg::*;

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RW = IW;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int PW = PAGE_BITS;

  typedef struct packed {
    logic          vld;
    logic [PW-1:0] page;
    logic          hit;
    logic [IW-1:0] hit_idx;
    logic [RW-1:0] hit_rank;
    logic          empty;
    logic [IW-1:0] empty_idx;
    logic [IW-1:0] min_idx;
    logic [RW-1:0] min_rank;
  } scan_t;

  typedef struct packed {
    upd_op_t       op;
    logic [IW-1:0] slot;
    logic [RW-1:0] old_rank;
    logic [RW-1:0] new_rank;
    logic [PW-1:0] page;
    logic          wr_page;
  } upd_t;

  logic [CFG_W-1:0]   frame_count;
  logic [CW-1:0]      act_cnt;
  logic               busy;
  logic               last_q;
  scan_t              fin;
  logic               fin_vld;
  logic [CW-1:0]      vcount;
  logic [FAULT_W-1:0] faults;
  logic [FAULT_W-1:0] faults_next;
  logic               apply;
  logic               fill;
  logic [IW-1:0]      slot;
  logic [RW-1:0]      old_rank;
  upd_t               upd;
  scan_t              link [MAX_FRAMES+1];

  assign s_tready = !busy;

  // Zero means one frame; above the built capacity saturates.
  always_comb begin
    if (frame_count == '0) begin
      act_cnt = CW'(1);
    end else if (int'(frame_count) > MAX_FRAMES) begin
      act_cnt = CW'(MAX_FRAMES);
    end else begin
      act_cnt = CW'(frame_count);
    end
  end

  always_comb begin
    link[0]      = '0;
    link[0].vld  = s_tvalid && s_tready;
    link[0].page = PW'(s_tdata);
  end

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    lrupr_cell #(
      .IDX    (i),
      .IW     (IW),
      .RW     (RW),
      .CW     (CW),
      .PW     (PW),
      .scan_t (scan_t),
      .upd_t  (upd_t)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .act_cnt (act_cnt),
      .acc_in  (link[i]),
      .acc_out (link[i+1]),
      .upd     (upd)
    );
  end

  // Decide on the finished scan: hit, fill an empty frame, or replace the oldest.
  assign apply = fin_vld && (!m_tvalid || m_tready);
  assign fill  = !fin.hit && fin.empty;

  always_comb begin
    priority if (fin.hit) begin
      slot     = fin.hit_idx;
      old_rank = fin.hit_rank;
    end else if (fin.empty) begin
      slot     = fin.empty_idx;
      old_rank = '0;
    end else begin
      slot     = fin.min_idx;
      old_rank = fin.min_rank;
    end
  end

  assign faults_next = (fin.hit || faults == '1) ? faults : faults + 1'b1;

  always_comb begin
    upd          = '0;
    upd.slot     = slot;
    upd.old_rank = old_rank;
    upd.new_rank = fill ? RW'(vcount) : RW'(vcount - 1'b1);
    upd.page     = fin.page;
    upd.wr_page  = !fin.hit;
    priority if (!apply) begin
      upd.op = UPD_NONE;
    end else if (last_q) begin
      upd.op = UPD_CLEAR;
    end else if (fill) begin
      upd.op = UPD_FILL;
    end else begin
      upd.op = UPD_TOUCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
      busy        <= 1'b0;
      fin_vld     <= 1'b0;
      m_tvalid    <= 1'b0;
      vcount      <= '0;
      faults      <= '0;
    end else begin
      if (cfg_we) begin
        frame_count <= cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        busy <= 1'b1;
      end
      if (link[MAX_FRAMES].vld) begin
        fin_vld <= 1'b1;
      end
      if (apply) begin
        fin_vld  <= 1'b0;
        busy     <= 1'b0;
        m_tvalid <= 1'b1;
        if (last_q) begin
          faults <= '0;
          vcount <= '0;
        end else begin
          faults <= faults_next;
          if (fill) begin
            vcount <= vcount + 1'b1;
          end
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the item's last flag, the finished scan record and the output payload.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      last_q <= s_tlast;
    end
    if (link[MAX_FRAMES].vld) begin
      fin <= link[MAX_FRAMES];
    end
    if (apply) begin
      m_tdata <= {(OUT_DATA_W - FAULT_W - SLOT_W)'(0), faults_next, SLOT_W'(slot)};
      m_tuser <= fin.hit;
      m_tlast <= last_q;
    end
  end

endmodule
